// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; the user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");

`define AST_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/nam_pkg.sv -----
`default_nettype none
package nam_pkg;
	localparam int ENTRIES_DEF = 32;
	localparam logic [31:0] TIMEOUT_RST = 32'd30000;
	localparam logic [15:0] NO_NODE = 16'hFFFF;

	typedef enum logic [3:0] {
		OP_STATIC = 4'd0,
		OP_REG    = 4'd1,
		OP_LEARN  = 4'd2,
		OP_SETMAC = 4'd3,
		OP_TOUCH  = 4'd4,
		OP_REMOVE = 4'd5,
		OP_BYMAC  = 4'd6,
		OP_BYIP   = 4'd7,
		OP_BYID   = 4'd8,
		OP_SWEEP  = 4'd9,
		OP_CLEAR  = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ORG_STATIC     = 2'd0,
		ORG_LEARNED    = 2'd1,
		ORG_REGISTERED = 2'd2
	} origin_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOD
	} state_t;

	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] ip;
		logic [15:0] node;
		logic [31:0] seen;
		origin_t     origin;
		logic        online;
	} entry_t;

	typedef struct packed {
		op_t         opcode;
		logic [47:0] mac_in;
		logic [31:0] ip_in;
		logic [15:0] node_in;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  slot;
		logic [15:0] node_out;
		logic [47:0] mac_out;
		logic [31:0] ip_out;
		origin_t     origin_out;
		logic        online_out;
		logic [5:0]  entry_count;
	} res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/node_address_map_table.sv -----
`default_nettype none
// Node address map table. A command beat is taken on cmd when start is high
// and busy is low; busy stays high until the result beat has been issued.
// The result appears on result with done high for exactly one cycle; the
// receiver cannot stall, so it must take the beat in that cycle.
// Every command scans all ENTRIES slots through the entry memory, one read
// per cycle, gathering the lowest node, MAC, IP and free hits and the
// eviction victim; the sweep writes back offline entries during that scan.
// A decision state then reads the chosen slot, and a modify state writes it
// back where the command updates it and issues the result. Done rises after
// the modify state when a slot is reported, and after the decision state for
// a sweep, a clear or a failed command. The next command may be accepted in
// the cycle done is high. timeout_ms is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle, as the block does not
// enforce this. Reset clears all valid bits and the entry count and loads
// timeout_ms with 30000, and the block is ready at once with no clearing pass.
module node_address_map_table #(
	parameter int ENTRIES = nam_pkg::ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire nam_pkg::cmd_t cmd,
	output logic               done,
	output nam_pkg::res_t      result,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata
);
	import nam_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES - 1);
	localparam logic [IW:0] NUM = (IW + 1)'(ENTRIES);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [31:0] timeout_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;
	logic [IW:0] iss_q;
	logic rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic fn_q, fm_q, fi_q, ff_q, fv_q;
	logic [IW-1:0] fn_idx_q, fm_idx_q, fi_idx_q, ff_idx_q, fv_idx_q;
	logic [31:0] oldest_q;
	logic [IW-1:0] slot_q;
	logic done_q;
	res_t res_q;

	entry_t rdata, wdata;
	logic we;
	logic [IW-1:0] waddr, raddr;

	logic tgt_ok;
	logic [IW-1:0] tgt_idx;
	status_t fail_st;
	logic direct;
	entry_t new_e;
	logic upd;
	logic [31:0] age;
	logic [IW+4:0] slot_ext;
	logic [CW+5:0] cnt_ext;

	nam_entry_ram #(.ENTRIES(ENTRIES), .IW(IW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign age = cmd_q.now_ms - rdata.seen;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (rd_vld_s1 && ({1'b0, rd_idx_s1} == LAST)) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = direct ? S_IDLE : S_MOD;
			end
			S_MOD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		tgt_ok = 1'b0;
		tgt_idx = '0;
		fail_st = ST_NOTFOUND;
		case (cmd_q.opcode)
			OP_STATIC: begin
				fail_st = ST_FULL;
				tgt_ok = fn_q || ff_q;
				tgt_idx = fn_q ? fn_idx_q : ff_idx_q;
			end
			OP_REG: begin
				fail_st = ST_FULL;
				tgt_ok = fn_q || fm_q || ff_q || fv_q;
				tgt_idx = fn_q ? fn_idx_q : fm_q ? fm_idx_q : ff_q ? ff_idx_q : fv_idx_q;
			end
			OP_LEARN: begin
				fail_st = ST_FULL;
				tgt_ok = fn_q || ff_q;
				tgt_idx = fn_q ? fn_idx_q : ff_idx_q;
			end
			OP_SETMAC, OP_TOUCH, OP_REMOVE, OP_BYID: begin
				tgt_ok = fn_q;
				tgt_idx = fn_idx_q;
			end
			OP_BYMAC: begin
				tgt_ok = fm_q;
				tgt_idx = fm_idx_q;
			end
			OP_BYIP: begin
				tgt_ok = fi_q;
				tgt_idx = fi_idx_q;
			end
			OP_SWEEP, OP_CLEAR: fail_st = ST_OK;
			default: fail_st = ST_NOTFOUND;
		endcase
		direct = !tgt_ok;
	end

	always_comb begin
		new_e = rdata;
		upd = 1'b1;
		case (cmd_q.opcode)
			OP_STATIC: new_e = '{cmd_q.mac_in, cmd_q.ip_in, cmd_q.node_in,
				cmd_q.now_ms, ORG_STATIC, 1'b0};
			OP_REG: new_e = '{cmd_q.mac_in, cmd_q.ip_in, cmd_q.node_in,
				cmd_q.now_ms, ORG_REGISTERED, 1'b1};
			OP_LEARN: begin
				if (fn_q) begin
					new_e.seen = cmd_q.now_ms;
					new_e.online = 1'b1;
				end else begin
					new_e = '{cmd_q.mac_in, cmd_q.ip_in, cmd_q.node_in,
						cmd_q.now_ms, ORG_LEARNED, 1'b1};
				end
			end
			OP_SETMAC: begin
				new_e.mac = cmd_q.mac_in;
				new_e.seen = cmd_q.now_ms;
				new_e.online = 1'b1;
			end
			OP_TOUCH: begin
				new_e.seen = cmd_q.now_ms;
				new_e.online = 1'b1;
			end
			default: upd = 1'b0;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
		raddr = iss_q[IW-1:0];
		we = 1'b0;
		waddr = rd_idx_s1;
		wdata = rdata;
		wdata.online = 1'b0;
		case (state_q)
			S_SCAN: begin
				we = rd_vld_s1 && (cmd_q.opcode == OP_SWEEP) && valid_q[rd_idx_s1]
					&& (rdata.origin != ORG_STATIC) && (age > timeout_q);
			end
			S_DECIDE: raddr = tgt_idx;
			S_MOD: begin
				we = upd;
				waddr = slot_q;
				wdata = new_e;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			timeout_q <= TIMEOUT_RST;
			valid_q <= '0;
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			rd_vld_s1 <= (state_q == S_SCAN) && (iss_q < NUM);
			if (cfg_we) timeout_q <= cfg_wdata;
			if (state_q == S_DECIDE && direct) begin
				done_q <= 1'b1;
				if (cmd_q.opcode == OP_CLEAR) begin
					valid_q <= '0;
					count_q <= '0;
				end
			end
			if (state_q == S_MOD) begin
				done_q <= 1'b1;
				if (cmd_q.opcode == OP_REMOVE) begin
					valid_q[slot_q] <= 1'b0;
					count_q <= count_q - 1'b1;
				end else if (upd) begin
					valid_q[slot_q] <= 1'b1;
					if (!valid_q[slot_q]) count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		slot_ext = {5'b0, slot_q};
		cnt_ext = {6'b0, count_q};
		if (state_q == S_MOD) begin
			if (cmd_q.opcode == OP_REMOVE) cnt_ext = {6'b0, count_q - 1'b1};
			else if (upd && !valid_q[slot_q]) cnt_ext = {6'b0, count_q + 1'b1};
		end else if (cmd_q.opcode == OP_CLEAR) begin
			cnt_ext = '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				iss_q <= '0;
				fn_q <= 1'b0;
				fm_q <= 1'b0;
				fi_q <= 1'b0;
				ff_q <= 1'b0;
				fv_q <= 1'b0;
				oldest_q <= 32'hFFFF_FFFF;
			end
			S_SCAN: begin
				if (iss_q < NUM) iss_q <= iss_q + 1'b1;
				rd_idx_s1 <= iss_q[IW-1:0];
				if (rd_vld_s1) begin
					if (valid_q[rd_idx_s1]) begin
						if (!fn_q && rdata.node == cmd_q.node_in) begin
							fn_q <= 1'b1;
							fn_idx_q <= rd_idx_s1;
						end
						if (!fm_q && rdata.mac == cmd_q.mac_in) begin
							fm_q <= 1'b1;
							fm_idx_q <= rd_idx_s1;
						end
						if (!fi_q && rdata.ip == cmd_q.ip_in) begin
							fi_q <= 1'b1;
							fi_idx_q <= rd_idx_s1;
						end
						if (rdata.origin != ORG_STATIC && rdata.seen < oldest_q) begin
							fv_q <= 1'b1;
							fv_idx_q <= rd_idx_s1;
							oldest_q <= rdata.seen;
						end
					end else if (!ff_q) begin
						ff_q <= 1'b1;
						ff_idx_q <= rd_idx_s1;
					end
				end
			end
			S_DECIDE: begin
				slot_q <= tgt_idx;
				res_q <= '{fail_st, 5'd0, NO_NODE, 48'd0, 32'd0, ORG_STATIC, 1'b0,
					cnt_ext[5:0]};
			end
			S_MOD: begin
				res_q <= '{ST_OK, slot_ext[4:0], new_e.node, new_e.mac, new_e.ip,
					new_e.origin, new_e.online, cnt_ext[5:0]};
			end
			default: res_q <= res_q;
		endcase
	end

	assign done = done_q;
	assign result = res_q;

	`include "assert_macros.svh"

	`AST_IMP(a_count_max, 1'b1, count_q <= CW'(ENTRIES))
	`AST_NXT(a_accept_busy, start && !busy, busy)
	`AST_NXT(a_done_single, done, !done)
	`AST_IMP(a_done_idle, done, !busy)
endmodule
`default_nettype wire

// ----- hw/rtl/nam_entry_ram.sv -----
`default_nettype none
module nam_entry_ram #(
	parameter int ENTRIES = nam_pkg::ENTRIES_DEF,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [IW-1:0]   waddr,
	input  wire nam_pkg::entry_t wdata,
	input  wire logic [IW-1:0]   raddr,
	output nam_pkg::entry_t      rdata
);
	import nam_pkg::*;

	entry_t mem [ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire
